// ===== rtl/i2crm_pkg.sv =====
// types and constants shared by the i2c register master
`timescale 1ns / 1ps

package i2crm_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd20;
   localparam logic [7:0] READ_BIT_MASK     = 8'h01;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   typedef enum logic [15:0] {
      PH_IDLE = 16'h0001,
      PH_ST0  = 16'h0002,
      PH_ST1  = 16'h0004,
      PH_ST2  = 16'h0008,
      PH_TX0  = 16'h0010,
      PH_TX1  = 16'h0020,
      PH_TX2  = 16'h0040,
      PH_AK0  = 16'h0080,
      PH_AK1  = 16'h0100,
      PH_AK2  = 16'h0200,
      PH_RX1  = 16'h0400,
      PH_RX2  = 16'h0800,
      PH_MA0  = 16'h1000,
      PH_MA1  = 16'h2000,
      PH_SP0  = 16'h4000,
      PH_SP1  = 16'h8000
   } phase_type;

   typedef enum logic [4:0] {
      STG_DEVW  = 5'b00001,
      STG_REG   = 5'b00010,
      STG_WDATA = 5'b00100,
      STG_DEVR  = 5'b01000,
      STG_RDATA = 5'b10000
   } stage_type;

   typedef struct packed {
      phase_type  phase;
      stage_type  stage;
      logic [7:0] delay_count;
      logic [3:0] bit_count;
      logic [7:0] bytes_left;
      logic [7:0] shift_reg;
      logic [6:0] latched_dev;
      logic [7:0] latched_reg;
      logic       is_read;
      logic       scl_drv;
      logic       sda_drv;
      logic       err;
      logic       ack_bad;
   } state_type;

   typedef struct packed {
      logic       nack_error;
      logic       done_res;
      logic       wr_taken;
      logic       rd_valid;
      logic [7:0] rd_data;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_IDLE,
      stage:       STG_DEVW,
      delay_count: 8'd0,
      bit_count:   4'd0,
      bytes_left:  8'd0,
      shift_reg:   8'd0,
      latched_dev: 7'd0,
      latched_reg: 8'd0,
      is_read:     1'b0,
      scl_drv:     1'b1,
      sda_drv:     1'b1,
      err:         1'b0,
      ack_bad:     1'b0
   };

endpackage

// ===== rtl/i2crm_step.sv =====
// next-state and result logic for one tick of the i2c register master
`timescale 1ns / 1ps

module i2crm_step (
   input  i2crm_pkg::state_type  state,
   input  logic [7:0]            phase_ticks,
   input  logic [1:0]            cmd,
   input  logic [6:0]            slave_addr,
   input  logic [7:0]            sub_addr,
   input  logic [7:0]            xfer_len,
   input  logic [7:0]            wr_data,
   input  logic                  sda_in,
   output i2crm_pkg::state_type  state_next,
   output i2crm_pkg::result_type result
);
   import i2crm_pkg::*;

   state_type  n;
   phase_type  np;
   logic       enter;
   logic [7:0] dc;
   logic       rdv;
   logic [7:0] rdd;
   logic       taken;
   logic       done;
   logic       nerr;

   always_comb begin
      n     = state;
      np    = state.phase;
      enter = 1'b0;
      rdv   = 1'b0;
      rdd   = 8'd0;
      taken = 1'b0;
      done  = 1'b0;
      nerr  = 1'b0;
      dc    = state.delay_count - 8'd1;

      if (state.phase == PH_IDLE) begin
         if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            n.latched_dev = slave_addr;
            n.latched_reg = sub_addr;
            n.bytes_left  = xfer_len;
            n.is_read     = (cmd == CMD_READ);
            n.stage       = STG_DEVW;
            n.err         = 1'b0;
            np            = PH_ST0;
            enter         = 1'b1;
         end
      end else begin
         n.delay_count = dc;
         if (dc == 8'd0) begin
            enter = 1'b1;
            case (state.phase)
               PH_ST0: np = PH_ST1;
               PH_ST1: np = PH_ST2;
               PH_ST2: begin
                  n.shift_reg = (state.stage == STG_DEVR) ?
                                ({state.latched_dev, 1'b0} | READ_BIT_MASK) :
                                {state.latched_dev, 1'b0};
                  n.bit_count = 4'd0;
                  np          = PH_TX0;
               end
               PH_TX0: np = PH_TX1;
               PH_TX1: np = PH_TX2;
               PH_TX2: begin
                  n.shift_reg = {state.shift_reg[6:0], 1'b0};
                  n.bit_count = state.bit_count + 4'd1;
                  np = (n.bit_count < BITS_PER_BYTE) ? PH_TX0 : PH_AK0;
               end
               PH_AK0: np = PH_AK1;
               PH_AK1: begin
                  n.ack_bad = sda_in;
                  np        = PH_AK2;
               end
               PH_AK2: begin
                  if (state.ack_bad) begin
                     n.err = 1'b1;
                     np    = PH_SP0;
                  end else if (state.stage == STG_DEVW) begin
                     n.stage     = STG_REG;
                     n.shift_reg = state.latched_reg;
                     n.bit_count = 4'd0;
                     np          = PH_TX0;
                  end else if (state.stage == STG_REG && state.is_read) begin
                     n.stage = STG_DEVR;
                     np      = PH_ST0;
                  end else if (state.stage == STG_REG || state.stage == STG_WDATA) begin
                     if (state.bytes_left != 8'd0) begin
                        n.stage      = STG_WDATA;
                        n.bytes_left = state.bytes_left - 8'd1;
                        n.shift_reg  = wr_data;
                        n.bit_count  = 4'd0;
                        taken        = 1'b1;
                        np           = PH_TX0;
                     end else begin
                        n.err = 1'b0;
                        np    = PH_SP0;
                     end
                  end else if (state.bytes_left != 8'd0) begin
                     // read address acked, start clocking in data
                     n.stage     = STG_RDATA;
                     n.shift_reg = 8'd0;
                     n.bit_count = 4'd0;
                     np          = PH_RX1;
                  end else begin
                     n.err = 1'b0;
                     np    = PH_SP0;
                  end
               end
               PH_RX1: begin
                  n.shift_reg = {state.shift_reg[6:0], sda_in};
                  n.bit_count = state.bit_count + 4'd1;
                  np          = PH_RX2;
               end
               PH_RX2: np = (state.bit_count < BITS_PER_BYTE) ? PH_RX1 : PH_MA0;
               PH_MA0: np = PH_MA1;
               PH_MA1: begin
                  rdv          = 1'b1;
                  rdd          = state.shift_reg;
                  n.bytes_left = state.bytes_left - 8'd1;
                  if (n.bytes_left != 8'd0) begin
                     n.stage     = STG_RDATA;
                     n.shift_reg = 8'd0;
                     n.bit_count = 4'd0;
                     np          = PH_RX1;
                  end else begin
                     n.err = 1'b0;
                     np    = PH_SP0;
                  end
               end
               PH_SP0: np = PH_SP1;
               default: begin
                  // stop hold over, back to idle
                  enter         = 1'b0;
                  n.phase       = PH_IDLE;
                  n.delay_count = 8'd0;
                  n.scl_drv     = 1'b1;
                  n.sda_drv     = 1'b1;
                  done          = 1'b1;
                  nerr          = state.err;
               end
            endcase
         end
      end

      if (enter) begin
         n.phase       = np;
         n.delay_count = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
         case (np)
            PH_ST0: begin
               n.scl_drv = 1'b1;
               n.sda_drv = 1'b1;
            end
            PH_ST1: n.sda_drv = 1'b0;
            PH_ST2: n.scl_drv = 1'b0;
            PH_TX0: n.sda_drv = n.shift_reg[7];
            PH_TX1: n.scl_drv = 1'b1;
            PH_TX2: n.scl_drv = 1'b0;
            PH_AK0: n.sda_drv = 1'b1;
            PH_AK1: n.scl_drv = 1'b1;
            PH_AK2: n.scl_drv = 1'b0;
            PH_RX1: begin
               n.scl_drv = 1'b1;
               n.sda_drv = 1'b1;
            end
            PH_RX2: n.scl_drv = 1'b0;
            PH_MA0: begin
               // nack on the last byte
               n.scl_drv = 1'b1;
               n.sda_drv = (n.bytes_left == 8'd1);
            end
            PH_MA1: n.scl_drv = 1'b0;
            PH_SP0: begin
               n.scl_drv = 1'b1;
               n.sda_drv = 1'b0;
            end
            PH_SP1: n.sda_drv = 1'b1;
            default: begin
               n.scl_drv = state.scl_drv;
            end
         endcase
      end
   end

   assign state_next        = n;
   assign result.scl_out    = n.scl_drv;
   assign result.sda_out    = n.sda_drv;
   assign result.busy_res   = (n.phase != PH_IDLE);
   assign result.rd_data    = rdd;
   assign result.rd_valid   = rdv;
   assign result.wr_taken   = taken;
   assign result.done_res   = done;
   assign result.nack_error = nerr;

endmodule

// ===== rtl/i2c_register_master_top.sv =====
// top level of the tick-driven i2c register master
`timescale 1ns / 1ps

// Each accepted req transaction is one bus timing tick: it may start a register
// write or read (ignored while busy) and carries the sampled SDA level and the
// next write byte. Every tick yields exactly one rsp transaction with the line
// drives and status pulses in the cycle after acceptance. One tick is accepted
// per cycle; the only limit is the single rsp output register, which accepts a
// new tick whenever it is empty or being taken in the same cycle. phase_ticks
// is written through csr_wr_en / csr_wr_data and is picked up at the next
// phase entry.

module i2c_register_master_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [31:0] req_tdata,   // slave_addr, sub_addr, xfer_len, wr_data, sda_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_out, sda_out, busy_res, rd_data, rd_valid, wr_taken, done_res, nack_error
   output logic [15:0] rsp_tdata
);
   import i2crm_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] phase_ticks_ff;
   logic       req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   i2crm_step u_step (
      .state       (state_ff),
      .phase_ticks (phase_ticks_ff),
      .cmd         (req_tuser),
      .slave_addr  (req_tdata[6:0]),
      .sub_addr    (req_tdata[14:7]),
      .xfer_len    (req_tdata[22:15]),
      .wr_data     (req_tdata[30:23]),
      .sda_in      (req_tdata[31]),
      .state_next  (state_in),
      .result      (result_in)
   );

   assign rsp_valid_in = req_take ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= STATE_RESET;
         rsp_valid_ff   <= 1'b0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

endmodule

// ===== tb/tb_i2c_register_master_top.sv =====
// self-checking testbench for the tick-driven i2c register master
`timescale 1ns / 1ps

module tb_i2c_register_master_top;
   import i2crm_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser   = CMD_TICK;  // cmd
   logic [31:0] req_tdata   = 32'd0;     // slave_addr, sub_addr, xfer_len, wr_data, sda_in
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // scl_out, sda_out, busy_res, rd_data, rd_valid, wr_taken, done_res, nack_error
   logic [15:0] rsp_tdata;

   i2c_register_master_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted bus sequencer state
   logic [7:0] phase_ticks_cfg = PHASE_TICKS_RESET;
   phase_type  bus_phase       = PH_IDLE;
   stage_type  stage_q         = STG_DEVW;
   logic [7:0] hold_left       = 8'd0;
   logic [3:0] bit_cnt         = 4'd0;
   logic [7:0] bytes_left_q    = 8'd0;
   logic [7:0] shift_q         = 8'd0;
   logic [6:0] dev_q           = 7'd0;
   logic [7:0] reg_q           = 8'd0;
   logic       is_read_q       = 1'b0;
   logic       scl_q           = 1'b1;
   logic       sda_q           = 1'b1;
   logic       err_q           = 1'b0;
   logic       ack_bad_q       = 1'b0;

   result_type tick_results_q[$];
   int         fail_count    = 0;
   int         ticks_sent    = 0;
   int         idle_cycles   = 0;
   bit         idle_on       = 1'b1;
   int         hold_requests = 0;
   int         holds_done    = 0;
   int         sink_stall    = 0;

   // target device behavior
   int nack_pct     = 0;
   int nack_at_ack  = -1;
   int acks_sampled = 0;
   int stray_pct    = 0;

   function automatic void enter_phase(phase_type p);
      bus_phase = p;
      hold_left = (phase_ticks_cfg == 8'd0) ? 8'd1 : phase_ticks_cfg;
      case (p)
         PH_ST0: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
         PH_ST1: sda_q = 1'b0;
         PH_ST2: scl_q = 1'b0;
         PH_TX0: sda_q = shift_q[7];
         PH_TX1: scl_q = 1'b1;
         PH_TX2: scl_q = 1'b0;
         PH_AK0: sda_q = 1'b1;
         PH_AK1: scl_q = 1'b1;
         PH_AK2: scl_q = 1'b0;
         PH_RX1: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
         PH_RX2: scl_q = 1'b0;
         PH_MA0: begin
            scl_q = 1'b1;
            sda_q = (bytes_left_q == 8'd1);
         end
         PH_MA1: scl_q = 1'b0;
         PH_SP0: begin
            scl_q = 1'b1;
            sda_q = 1'b0;
         end
         PH_SP1: sda_q = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic void load_byte(logic [7:0] value);
      shift_q = value;
      bit_cnt = 4'd0;
      enter_phase(PH_TX0);
   endfunction

   function automatic void begin_stop(logic nacked);
      err_q = nacked;
      enter_phase(PH_SP0);
   endfunction

   function automatic void start_read_byte();
      stage_q = STG_RDATA;
      shift_q = 8'd0;
      bit_cnt = 4'd0;
      enter_phase(PH_RX1);
   endfunction

   // returns 1 when the write byte is consumed
   function automatic logic next_write_byte(logic [7:0] wbyte);
      if (bytes_left_q == 8'd0) begin
         begin_stop(1'b0);
         return 1'b0;
      end
      stage_q = STG_WDATA;
      bytes_left_q--;
      load_byte(wbyte);
      return 1'b1;
   endfunction

   function automatic result_type predict_tick(logic [1:0] cmd, logic [31:0] data);
      result_type r;
      logic       sda;
      logic [7:0] wbyte;
      r     = '0;
      sda   = data[31];
      wbyte = data[30:23];
      if (bus_phase == PH_IDLE) begin
         if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            dev_q        = data[6:0];
            reg_q        = data[14:7];
            bytes_left_q = data[22:15];
            is_read_q    = (cmd == CMD_READ);
            stage_q      = STG_DEVW;
            err_q        = 1'b0;
            enter_phase(PH_ST0);
         end
      end else begin
         hold_left--;
         if (hold_left == 8'd0) begin
            case (bus_phase)
               PH_ST0: enter_phase(PH_ST1);
               PH_ST1: enter_phase(PH_ST2);
               PH_ST2: begin
                  if (stage_q == STG_DEVR) load_byte({dev_q, 1'b0} | READ_BIT_MASK);
                  else load_byte({dev_q, 1'b0});
               end
               PH_TX0: enter_phase(PH_TX1);
               PH_TX1: enter_phase(PH_TX2);
               PH_TX2: begin
                  shift_q = shift_q << 1;
                  bit_cnt++;
                  if (bit_cnt < BITS_PER_BYTE) enter_phase(PH_TX0);
                  else enter_phase(PH_AK0);
               end
               PH_AK0: enter_phase(PH_AK1);
               PH_AK1: begin
                  ack_bad_q = sda;
                  enter_phase(PH_AK2);
               end
               PH_AK2: begin
                  if (ack_bad_q) begin
                     begin_stop(1'b1);
                  end else if (stage_q == STG_DEVW) begin
                     stage_q = STG_REG;
                     load_byte(reg_q);
                  end else if (stage_q == STG_REG && is_read_q) begin
                     // repeated start for the read address
                     stage_q = STG_DEVR;
                     enter_phase(PH_ST0);
                  end else if (stage_q == STG_REG || stage_q == STG_WDATA) begin
                     r.wr_taken = next_write_byte(wbyte);
                  end else if (bytes_left_q != 8'd0) begin
                     start_read_byte();
                  end else begin
                     begin_stop(1'b0);
                  end
               end
               PH_RX1: begin
                  shift_q = {shift_q[6:0], sda};
                  bit_cnt++;
                  enter_phase(PH_RX2);
               end
               PH_RX2: begin
                  if (bit_cnt < BITS_PER_BYTE) enter_phase(PH_RX1);
                  else enter_phase(PH_MA0);
               end
               PH_MA0: enter_phase(PH_MA1);
               PH_MA1: begin
                  r.rd_valid = 1'b1;
                  r.rd_data  = shift_q;
                  bytes_left_q--;
                  if (bytes_left_q != 8'd0) start_read_byte();
                  else begin_stop(1'b0);
               end
               PH_SP0: enter_phase(PH_SP1);
               default: begin
                  bus_phase    = PH_IDLE;
                  hold_left    = 8'd0;
                  scl_q        = 1'b1;
                  sda_q        = 1'b1;
                  r.done_res   = 1'b1;
                  r.nack_error = err_q;
               end
            endcase
         end
      end
      r.scl_out  = scl_q;
      r.sda_out  = sda_q;
      r.busy_res = (bus_phase != PH_IDLE);
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // sda level of the target: only the last tick of the ack clock is sampled
   function automatic logic slave_sda();
      logic nack;
      if (bus_phase != PH_AK1 || hold_left != 8'd1) return 1'($urandom);
      if (nack_at_ack >= 0) nack = (acks_sampled == nack_at_ack);
      else nack = ($urandom_range(1, 100) <= nack_pct);
      acks_sampled++;
      return nack;
   endfunction

   function automatic logic [1:0] stray_cmd();
      if ($urandom_range(1, 100) <= stray_pct) return 2'($urandom);
      return CMD_TICK;
   endfunction

   task automatic send_tick(logic [1:0] cmd, logic [6:0] dev, logic [7:0] reg_byte,
                            logic [7:0] len);
      int          gap;
      logic [31:0] data;
      gap  = pick_gap();
      data = {slave_sda(), 8'($urandom), len, reg_byte, dev};
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      tick_results_q.push_back(predict_tick(cmd, data));
      ticks_sent++;
   endtask

   // issue one command, then keep ticking until the bus is idle again
   task automatic run_command(logic [1:0] cmd, logic [6:0] dev, logic [7:0] reg_byte,
                              logic [7:0] len);
      acks_sampled = 0;
      send_tick(cmd, dev, reg_byte, len);
      while (bus_phase != PH_IDLE)
         send_tick(stray_cmd(), 7'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic set_phase_ticks(logic [7:0] value);
      req_tvalid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      phase_ticks_cfg = value;
   endtask

   // the address is nacked so the reset hold length is seen on a short transaction
   task automatic test_reset_phase_ticks();
      nack_at_ack = 0;
      nack_pct    = 0;
      run_command(CMD_WRITE, 7'h2A, 8'h5C, 8'd0);
      nack_at_ack = -1;
   endtask

   task automatic test_idle_ticks();
      run_command(CMD_TICK, 7'h7F, 8'hFF, 8'hFF);
      run_command(CMD_UNUSED, 7'h00, 8'h00, 8'h00);
      run_command(CMD_UNUSED, 7'h7F, 8'hFF, 8'hFF);
   endtask

   task automatic test_zero_length();
      nack_pct = 0;
      run_command(CMD_WRITE, 7'h00, 8'h00, 8'd0);
      run_command(CMD_READ, 7'h7F, 8'hFF, 8'd0);
   endtask

   task automatic test_data_transfers();
      nack_pct = 0;
      run_command(CMD_WRITE, 7'h55, 8'hAA, 8'd2);
      run_command(CMD_READ, 7'h55, 8'hAA, 8'd1);
      run_command(CMD_READ, 7'h2A, 8'h55, 8'd3);
   endtask

   task automatic test_busy_commands();
      nack_pct  = 0;
      stray_pct = 100;
      run_command(CMD_WRITE, 7'h11, 8'h22, 8'd1);
      stray_pct    = 0;
      acks_sampled = 0;
      send_tick(CMD_READ, 7'h44, 8'h88, 8'd1);
      // a command on the tick the stop hold ends must be ignored
      while (!(bus_phase == PH_SP1 && hold_left == 8'd1))
         send_tick(CMD_TICK, 7'h00, 8'h00, 8'h00);
      send_tick(CMD_WRITE, 7'h7F, 8'hFF, 8'd1);
   endtask

   task automatic test_nack_abort();
      nack_at_ack = 0;
      run_command(CMD_WRITE, 7'h7F, 8'hFF, 8'hFF);
      nack_at_ack = 1;
      run_command(CMD_WRITE, 7'h01, 8'h80, 8'd1);
      nack_at_ack = 3;
      run_command(CMD_WRITE, 7'h40, 8'h01, 8'hFF);
      nack_at_ack = 2;
      run_command(CMD_READ, 7'h3F, 8'hFE, 8'hFF);
      nack_at_ack = -1;
   endtask

   task automatic test_output_backpressure();
      nack_pct = 0;
      hold_requests <= hold_requests + 1;
      run_command(CMD_WRITE, 7'h3C, 8'hC3, 8'd2);
   endtask

   task automatic test_slow_phase();
      idle_on     <= 1'b0;
      nack_at_ack = 0;
      run_command(CMD_READ, 7'h12, 8'h34, 8'd5);
      nack_at_ack = -1;
      idle_on     <= 1'b1;
   endtask

   task automatic test_random_traffic(int tick_budget);
      int         first_tick;
      int         roll;
      logic [7:0] len;
      first_tick  = ticks_sent;
      stray_pct   = 10;
      nack_at_ack = -1;
      while (ticks_sent - first_tick < tick_budget) begin
         if ($urandom_range(0, 9) == 0) idle_on <= !idle_on;
         nack_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20);
         roll     = $urandom_range(0, 99);
         len      = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
         if (roll < 8) begin
            run_command(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_UNUSED,
                        7'($urandom), 8'($urandom), 8'($urandom));
         end else if (roll < 54) begin
            // long writes end early on a nack
            if (len > 8'd4) nack_pct = 25;
            run_command(CMD_WRITE, 7'($urandom), 8'($urandom), len);
         end else begin
            run_command(CMD_READ, 7'($urandom), 8'($urandom), 8'($urandom_range(0, 4)));
         end
      end
      idle_on   <= 1'b1;
      stray_pct = 0;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, seen);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[14:0];
         if (tick_results_q.size() == 0) begin
            $error("rsp transaction with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = tick_results_q.pop_front();
            check_field("scl_out", 8'(want.scl_out), 8'(seen.scl_out));
            check_field("sda_out", 8'(want.sda_out), 8'(seen.sda_out));
            check_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
            check_field("rd_data", want.rd_data, seen.rd_data);
            check_field("rd_valid", 8'(want.rd_valid), 8'(seen.rd_valid));
            check_field("wr_taken", 8'(want.wr_taken), 8'(seen.wr_taken));
            check_field("done_res", 8'(want.done_res), 8'(seen.done_res));
            check_field("nack_error", 8'(want.nack_error), 8'(seen.nack_error));
            check_field("pad", 8'd0, 8'(rsp_tdata[15]));
         end
      end
   end

   always @(posedge clock) begin : rsp_sink
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done <= holds_done + 1;
         sink_stall <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         gap = pick_gap();
         if (gap > 0) begin
            sink_stall <= gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("i2c_register_master_top regression: fail");
      $finish;
   end

   initial begin : run_tests
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_phase_ticks();
      set_phase_ticks(8'd0);
      test_idle_ticks();
      test_zero_length();
      test_data_transfers();
      test_busy_commands();
      test_nack_abort();

      set_phase_ticks(8'd1);
      test_output_backpressure();
      test_random_traffic(150);

      set_phase_ticks(8'd7);
      test_slow_phase();

      set_phase_ticks(8'd2);
      test_random_traffic(60);

      set_phase_ticks(8'($urandom_range(3, 6)));
      test_random_traffic(60);

      req_tvalid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("i2c_register_master_top regression: pass");
      end else begin
         $display("i2c_register_master_top regression: fail");
      end
      $finish;
   end

endmodule
